// ----- src/usg_pkg.sv -----
package usg_pkg;

    // register indexes of the configuration port
    localparam logic REG_BAND_COUNT  = 1'b0;
    localparam logic REG_WEDGE_COUNT = 1'b1;

    // Q62 magnitude with a separate sign
    typedef struct packed {
        logic        neg;
        logic [62:0] mag;
    } trig_t;

    // sine and cosine of one angle
    typedef struct packed {
        trig_t sn;
        trig_t cs;
    } angle_t;

    // angles 0,1: top and bottom band, angles 2,3: left and right wedge
    typedef angle_t [3:0] bundle_t;

endpackage

// ----- src/usg_mul.sv -----
module usg_mul
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         done,
    output logic [127:0] prod
);

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [127:0] acc_reg;
    logic [1:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [63:0]  pp;
    logic [127:0] pp_shift;

    // one 32x32 partial product per cycle
    assign a_half = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
    assign pp     = a_half * b_half;

    always_comb
    begin
        case (cnt_reg) inside
            2'd0:       pp_shift = {64'd0, pp};
            2'd1, 2'd2: pp_shift = {32'd0, pp, 32'd0};
            default:    pp_shift = {pp, 64'd0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            b_reg    <= '0;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            a_reg    <= a;
            b_reg    <= b;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_reg + pp_shift;
            cnt_reg  <= cnt_reg + 2'd1;
            busy_reg <= (cnt_reg != 2'd3);
            done_reg <= (cnt_reg == 2'd3);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ----- src/usg_div.sv -----
module usg_div #(
    parameter int DIV_W = 9
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [63:0]      dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [63:0]      quot,
    output logic [DIV_W-1:0] rem
);

    logic [63:0]      num_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] d_reg;
    logic [2:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [63:0]      num_next;
    logic [DIV_W-1:0] rem_next;

    // restoring division, eight quotient bits per cycle
    always_comb
    begin
        logic [DIV_W:0] r;
        logic [63:0]    n;
        r = {1'b0, rem_reg};
        n = num_reg;
        for (int i = 0; i < 8; i++)
        begin
            r = {r[DIV_W-1:0], n[63]};
            n = {n[62:0], 1'b0};
            if (r >= {1'b0, d_reg})
            begin
                r    = r - {1'b0, d_reg};
                n[0] = 1'b1;
            end
        end
        num_next = n;
        rem_next = r[DIV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg  <= '0;
            rem_reg  <= '0;
            d_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            num_reg  <= dividend;
            rem_reg  <= '0;
            d_reg    <= divisor;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg  <= num_next;
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_reg + 3'd1;
            busy_reg <= (cnt_reg != 3'd7);
            done_reg <= (cnt_reg == 3'd7);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign quot = num_reg;
    assign rem  = rem_reg;

endmodule

// ----- src/usg_front.sv -----
module usg_front #(
    parameter int INDEX_WIDTH = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [INDEX_WIDTH-1:0] band_index,
    input  logic [INDEX_WIDTH-1:0] wedge_index,
    input  logic                   cfg_we,
    input  logic                   cfg_addr,
    input  logic [INDEX_WIDTH-1:0] cfg_wdata,
    output logic                   push_valid,
    input  logic                   push_ready,
    output usg_pkg::bundle_t       push_data
);

    localparam int DIV_W = (INDEX_WIDTH + 1 > 8) ? INDEX_WIDTH + 1 : 8;
    localparam int NUM_W = INDEX_WIDTH + 1;
    localparam logic [63:0] Q_QUARTER_PI = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] Q_ONE        = 64'h4000_0000_0000_0000;

    typedef enum logic [3:0] {
        S_IDLE, S_PREB, S_PREW, S_MOD, S_OCT, S_MQ, S_MR, S_DR,
        S_SQ, S_SMUL, S_SDIV, S_CMUL, S_CDIV, S_SFIN, S_PUSH
    } step_t;

    function automatic logic [7:0] sin_div(input logic [2:0] i);
        case (i)
            3'd0:    sin_div = 8'd110;
            3'd1:    sin_div = 8'd72;
            3'd2:    sin_div = 8'd42;
            3'd3:    sin_div = 8'd20;
            default: sin_div = 8'd6;
        endcase
    endfunction

    function automatic logic [7:0] cos_div(input logic [2:0] i);
        case (i)
            3'd0:    cos_div = 8'd132;
            3'd1:    cos_div = 8'd90;
            3'd2:    cos_div = 8'd56;
            3'd3:    cos_div = 8'd30;
            3'd4:    cos_div = 8'd12;
            default: cos_div = 8'd2;
        endcase
    endfunction

    step_t                  step_reg;
    logic                   wait_reg;
    logic [1:0]             ang_reg;
    logic [2:0]             cnt_reg;
    logic                   stale_reg;
    logic                   hold_full_reg;
    logic [INDEX_WIDTH-1:0] hold_b_reg;
    logic [INDEX_WIDTH-1:0] hold_w_reg;
    logic [INDEX_WIDTH-1:0] tile_b_reg;
    logic [INDEX_WIDTH-1:0] tile_w_reg;
    logic [INDEX_WIDTH-1:0] band_reg;
    logic [INDEX_WIDTH-1:0] wedge_reg;
    logic [63:0]            qb_reg;
    logic [DIV_W-1:0]       rb_reg;
    logic [63:0]            qw_reg;
    logic [DIV_W-1:0]       rw_reg;
    logic [DIV_W-1:0]       rem0_reg;
    logic [2:0]             k_reg;
    logic [DIV_W-1:0]       rem_reg;
    logic [63:0]            acc_reg;
    logic [63:0]            t_reg;
    logic [63:0]            a_reg;
    logic [63:0]            x2_reg;
    logic [63:0]            ts_reg;
    logic [63:0]            tc_reg;
    usg_pkg::bundle_t       bundle_reg;

    logic [INDEX_WIDTH-1:0] band_eff;
    logic [INDEX_WIDTH-1:0] wedge_eff;
    logic [DIV_W-1:0]       den_b;
    logic [DIV_W-1:0]       den_w;
    logic [DIV_W-1:0]       den_sel;
    logic [63:0]            q_sel;
    logic [DIV_W-1:0]       r_sel;
    logic [NUM_W-1:0]       num_sel;
    logic                   is_mul;
    logic                   is_div;
    logic                   mul_start;
    logic                   div_start;
    logic [63:0]            mul_a;
    logic [63:0]            mul_b;
    logic [63:0]            div_n;
    logic [DIV_W-1:0]       div_d;
    logic                   mul_done;
    logic [127:0]           mul_prod;
    logic [63:0]            mulq;
    logic                   div_done;
    logic [63:0]            div_quot;
    logic [DIV_W-1:0]       div_rem;
    logic                   op_done;
    logic [62:0]            s_oct;
    logic [62:0]            c_oct;
    usg_pkg::angle_t        new_ang;

    // counts below the minimum act as the minimum
    assign band_eff  = (band_reg < INDEX_WIDTH'(2)) ? INDEX_WIDTH'(2) : band_reg;
    assign wedge_eff = (wedge_reg < INDEX_WIDTH'(3)) ? INDEX_WIDTH'(3) : wedge_reg;
    assign den_b     = DIV_W'({band_eff, 1'b0});
    assign den_w     = DIV_W'(wedge_eff);

    assign den_sel = ang_reg[1] ? den_w  : den_b;
    assign q_sel   = ang_reg[1] ? qw_reg : qb_reg;
    assign r_sel   = ang_reg[1] ? rw_reg : rb_reg;
    assign num_sel = {1'b0, (ang_reg[1] ? tile_w_reg : tile_b_reg)} + NUM_W'(ang_reg[0]);

    assign is_mul = (step_reg == S_MQ) || (step_reg == S_MR) || (step_reg == S_SQ) ||
                    (step_reg == S_SMUL) || (step_reg == S_CMUL) || (step_reg == S_SFIN);
    assign is_div = (step_reg == S_PREB) || (step_reg == S_PREW) || (step_reg == S_MOD) ||
                    (step_reg == S_OCT) || (step_reg == S_DR) || (step_reg == S_SDIV) ||
                    (step_reg == S_CDIV);
    assign mul_start = is_mul && !wait_reg;
    assign div_start = is_div && !wait_reg;
    assign op_done   = mul_done || div_done;
    assign mulq      = mul_prod[125:62];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        div_n = '0;
        div_d = den_sel;
        unique case (step_reg)
            S_PREB:
            begin
                div_n = Q_QUARTER_PI;
                div_d = den_b;
            end
            S_PREW:
            begin
                div_n = Q_QUARTER_PI;
                div_d = den_w;
            end
            S_MOD:  div_n = 64'(num_sel);
            S_OCT:  div_n = 64'({rem0_reg, 3'b000});
            S_MQ:
            begin
                mul_a = 64'(rem_reg);
                mul_b = q_sel;
            end
            S_MR:
            begin
                mul_a = 64'(rem_reg);
                mul_b = 64'(r_sel);
            end
            S_DR:   div_n = t_reg;
            S_SQ:
            begin
                mul_a = a_reg;
                mul_b = a_reg;
            end
            S_SMUL:
            begin
                mul_a = x2_reg;
                mul_b = ts_reg;
            end
            S_SDIV:
            begin
                div_n = t_reg;
                div_d = DIV_W'(sin_div(cnt_reg));
            end
            S_CMUL:
            begin
                mul_a = x2_reg;
                mul_b = tc_reg;
            end
            S_CDIV:
            begin
                div_n = t_reg;
                div_d = DIV_W'(cos_div(cnt_reg));
            end
            S_SFIN:
            begin
                mul_a = a_reg;
                mul_b = ts_reg;
            end
            default:
            begin
                div_n = '0;
            end
        endcase
    end

    // odd octants mirror the angle, swapping sine and cosine
    always_comb
    begin
        s_oct = k_reg[0] ? tc_reg[62:0] : mulq[62:0];
        c_oct = k_reg[0] ? mulq[62:0]   : tc_reg[62:0];
        case (k_reg[2:1])
            2'd0:    new_ang = '{sn: '{neg: 1'b0, mag: s_oct}, cs: '{neg: 1'b0, mag: c_oct}};
            2'd1:    new_ang = '{sn: '{neg: 1'b0, mag: c_oct}, cs: '{neg: 1'b1, mag: s_oct}};
            2'd2:    new_ang = '{sn: '{neg: 1'b1, mag: s_oct}, cs: '{neg: 1'b1, mag: c_oct}};
            default: new_ang = '{sn: '{neg: 1'b1, mag: c_oct}, cs: '{neg: 1'b0, mag: s_oct}};
        endcase
    end

    usg_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    usg_div #(.DIV_W(DIV_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_IDLE;
            wait_reg      <= 1'b0;
            ang_reg       <= '0;
            cnt_reg       <= '0;
            stale_reg     <= 1'b1;
            hold_full_reg <= 1'b0;
            hold_b_reg    <= '0;
            hold_w_reg    <= '0;
            tile_b_reg    <= '0;
            tile_w_reg    <= '0;
            band_reg      <= INDEX_WIDTH'(2);
            wedge_reg     <= INDEX_WIDTH'(3);
            qb_reg        <= '0;
            rb_reg        <= '0;
            qw_reg        <= '0;
            rw_reg        <= '0;
            rem0_reg      <= '0;
            k_reg         <= '0;
            rem_reg       <= '0;
            acc_reg       <= '0;
            t_reg         <= '0;
            a_reg         <= '0;
            x2_reg        <= '0;
            ts_reg        <= '0;
            tc_reg        <= '0;
            bundle_reg    <= '0;
        end
        else
        begin
            // configuration; divisor tables are rebuilt afterwards
            if (cfg_we)
            begin
                if (cfg_addr == usg_pkg::REG_BAND_COUNT)
                    band_reg <= cfg_wdata;
                else
                    wedge_reg <= cfg_wdata;
                stale_reg <= 1'b1;
            end
            else if (step_reg == S_PREB && !wait_reg)
            begin
                stale_reg <= 1'b0;
            end

            if (in_valid && !hold_full_reg)
            begin
                hold_full_reg <= 1'b1;
                hold_b_reg    <= band_index;
                hold_w_reg    <= wedge_index;
            end

            if ((is_mul || is_div) && !wait_reg)
                wait_reg <= 1'b1;

            unique case (step_reg)
                S_IDLE:
                begin
                    if (stale_reg)
                    begin
                        step_reg <= S_PREB;
                    end
                    else if (hold_full_reg)
                    begin
                        hold_full_reg <= 1'b0;
                        tile_b_reg    <= hold_b_reg;
                        tile_w_reg    <= hold_w_reg;
                        ang_reg       <= '0;
                        step_reg      <= S_MOD;
                    end
                end
                S_PUSH:
                begin
                    if (push_ready)
                        step_reg <= S_IDLE;
                end
                default:
                begin
                    if (wait_reg && op_done)
                    begin
                        wait_reg <= 1'b0;
                        unique case (step_reg)
                            S_PREB:
                            begin
                                qb_reg   <= div_quot;
                                rb_reg   <= div_rem;
                                step_reg <= S_PREW;
                            end
                            S_PREW:
                            begin
                                qw_reg   <= div_quot;
                                rw_reg   <= div_rem;
                                step_reg <= S_IDLE;
                            end
                            S_MOD:
                            begin
                                rem0_reg <= div_rem;
                                step_reg <= S_OCT;
                            end
                            S_OCT:
                            begin
                                k_reg    <= div_quot[2:0];
                                rem_reg  <= div_quot[0] ? den_sel - div_rem : div_rem;
                                step_reg <= S_MQ;
                            end
                            S_MQ:
                            begin
                                acc_reg  <= mul_prod[63:0];
                                step_reg <= S_MR;
                            end
                            S_MR:
                            begin
                                t_reg    <= mul_prod[63:0];
                                step_reg <= S_DR;
                            end
                            S_DR:
                            begin
                                a_reg    <= acc_reg + div_quot;
                                step_reg <= S_SQ;
                            end
                            S_SQ:
                            begin
                                x2_reg   <= mulq;
                                ts_reg   <= Q_ONE;
                                tc_reg   <= Q_ONE;
                                cnt_reg  <= '0;
                                step_reg <= S_SMUL;
                            end
                            S_SMUL:
                            begin
                                t_reg    <= mulq;
                                step_reg <= S_SDIV;
                            end
                            S_SDIV:
                            begin
                                ts_reg <= Q_ONE - div_quot;
                                if (cnt_reg == 3'd4)
                                begin
                                    cnt_reg  <= '0;
                                    step_reg <= S_CMUL;
                                end
                                else
                                begin
                                    cnt_reg  <= cnt_reg + 3'd1;
                                    step_reg <= S_SMUL;
                                end
                            end
                            S_CMUL:
                            begin
                                t_reg    <= mulq;
                                step_reg <= S_CDIV;
                            end
                            S_CDIV:
                            begin
                                tc_reg <= Q_ONE - div_quot;
                                if (cnt_reg == 3'd5)
                                begin
                                    cnt_reg  <= '0;
                                    step_reg <= S_SFIN;
                                end
                                else
                                begin
                                    cnt_reg  <= cnt_reg + 3'd1;
                                    step_reg <= S_CMUL;
                                end
                            end
                            S_SFIN:
                            begin
                                bundle_reg[ang_reg] <= new_ang;
                                if (ang_reg == 2'd3)
                                begin
                                    step_reg <= S_PUSH;
                                end
                                else
                                begin
                                    ang_reg  <= ang_reg + 2'd1;
                                    step_reg <= S_MOD;
                                end
                            end
                            default:
                            begin
                                step_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    assign in_ready   = !hold_full_reg;
    assign push_valid = (step_reg == S_PUSH);
    assign push_data  = bundle_reg;

endmodule

// ----- src/usg_queue.sv -----
module usg_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  usg_pkg::bundle_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output usg_pkg::bundle_t out_data
);

    usg_pkg::bundle_t mem [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// ----- src/usg_back.sv -----
module usg_back #(
    parameter int FRAC_BITS = 14
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     pop_valid,
    output logic                                     pop_ready,
    input  usg_pkg::bundle_t                         pop_data,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [((6 * FRAC_BITS + 9 + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                                     m_tlast
);

    localparam int OUT_BITS  = 6 * FRAC_BITS + 9;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;
    localparam int POS_DROP  = 63 - FRAC_BITS;
    localparam int NORM_DROP = 62 - FRAC_BITS;
    localparam logic [64:0] POS_HALF  = 65'd1 << (POS_DROP - 1);
    localparam logic [64:0] NORM_HALF = 65'd1 << (NORM_DROP - 1);

    typedef enum logic [1:0] {B_IDLE, B_NX, B_NZ, B_OUT} bstate_t;

    // round to nearest on the magnitude, ties away from zero, then sign
    function automatic logic [FRAC_BITS:0] round_pos(input logic [63:0] mag, input logic neg);
        logic [64:0]        sum;
        logic [FRAC_BITS:0] r;
        sum = {1'b0, mag} + POS_HALF;
        r   = sum[POS_DROP +: FRAC_BITS + 1];
        round_pos = neg ? -r : r;
    endfunction

    function automatic logic [FRAC_BITS+1:0] round_norm(input logic [63:0] mag,
                                                         input logic neg);
        logic [64:0]          sum;
        logic [FRAC_BITS+1:0] r;
        sum = {1'b0, mag} + NORM_HALF;
        r   = sum[NORM_DROP +: FRAC_BITS + 2];
        round_norm = neg ? -r : r;
    endfunction

    // corner order TL, BL, BR, TL, BR, TR
    function automatic logic corner_band(input logic [2:0] v);
        case (v) inside
            3'd1, 3'd2, 3'd4: corner_band = 1'b1;
            default:          corner_band = 1'b0;
        endcase
    endfunction

    function automatic logic corner_wedge(input logic [2:0] v);
        case (v) inside
            3'd2, 3'd4, 3'd5: corner_wedge = 1'b1;
            default:          corner_wedge = 1'b0;
        endcase
    endfunction

    bstate_t          state_reg;
    logic             wait_reg;
    logic [2:0]       vtx_reg;
    usg_pkg::bundle_t bund_reg;
    logic [63:0]      nx_reg;
    logic [63:0]      nz_reg;
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    logic             m_tlast_reg;

    usg_pkg::trig_t   sp;
    usg_pkg::trig_t   cp;
    usg_pkg::trig_t   st;
    usg_pkg::trig_t   ct;
    logic             nx_neg;
    logic             nz_neg;
    logic             mul_start;
    logic [63:0]      mul_b;
    logic             mul_done;
    logic [127:0]     mul_prod;
    logic             out_free;
    logic [OUT_W-1:0] tdata_next;

    assign sp     = bund_reg[{1'b0, corner_band(vtx_reg)}].sn;
    assign cp     = bund_reg[{1'b0, corner_band(vtx_reg)}].cs;
    assign st     = bund_reg[{1'b1, corner_wedge(vtx_reg)}].sn;
    assign ct     = bund_reg[{1'b1, corner_wedge(vtx_reg)}].cs;
    assign nx_neg = sp.neg ^ ct.neg;
    assign nz_neg = !(sp.neg ^ st.neg);

    assign mul_start = ((state_reg == B_NX) || (state_reg == B_NZ)) && !wait_reg;
    assign mul_b     = (state_reg == B_NZ) ? 64'(st.mag) : 64'(ct.mag);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign pop_ready = (state_reg == B_IDLE);

    assign tdata_next = OUT_W'({round_norm(nz_reg, nz_neg),
                                round_norm(64'(cp.mag), cp.neg),
                                round_norm(nx_reg, nx_neg),
                                round_pos(nz_reg, nz_neg),
                                round_pos(64'(cp.mag), cp.neg),
                                round_pos(nx_reg, nx_neg)});

    usg_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (64'(sp.mag)),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            wait_reg     <= 1'b0;
            vtx_reg      <= '0;
            bund_reg     <= '0;
            nx_reg       <= '0;
            nz_reg       <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            // a word taken with no new one loaded empties the output register
            if (m_tready && !((state_reg == B_OUT) && out_free))
                m_tvalid_reg <= 1'b0;
            if (mul_start)
                wait_reg <= 1'b1;

            unique case (state_reg)
                B_IDLE:
                begin
                    if (pop_valid)
                    begin
                        bund_reg  <= pop_data;
                        vtx_reg   <= '0;
                        state_reg <= B_NX;
                    end
                end
                B_NX:
                begin
                    if (wait_reg && mul_done)
                    begin
                        wait_reg  <= 1'b0;
                        nx_reg    <= mul_prod[125:62];
                        state_reg <= B_NZ;
                    end
                end
                B_NZ:
                begin
                    if (wait_reg && mul_done)
                    begin
                        wait_reg  <= 1'b0;
                        nz_reg    <= mul_prod[125:62];
                        state_reg <= B_OUT;
                    end
                end
                B_OUT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= tdata_next;
                        m_tlast_reg  <= (vtx_reg == 3'd5);
                        if (vtx_reg == 3'd5)
                        begin
                            state_reg <= B_IDLE;
                        end
                        else
                        begin
                            vtx_reg   <= vtx_reg + 3'd1;
                            state_reg <= B_NX;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ----- src/uv_sphere_tile_generator.sv -----
// the front's shared 64-bit multiplier and 8-bit-per-cycle divider work through
//   four angles per accepted tile (octant reduction plus two series each) before
//   its first vertex word; the next tile can wait in the front's hold register
// six words go out per tile
// reset: asynchronous, active low; counts return to 2 bands and 3 wedges and
//   the angle divisors are rebuilt before the first tile
module uv_sphere_tile_generator #(
    parameter int INDEX_WIDTH = 8,
    parameter int FRAC_BITS   = 14
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    // tdata: band_index, wedge_index
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    input  logic [((2 * INDEX_WIDTH + 7) / 8) * 8 - 1:0]   s_tdata,
    // tdata: pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, zero fill
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    output logic [((6 * FRAC_BITS + 9 + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                                          m_tlast,
    // register 0 band_count, register 1 wedge_count
    input  logic                                          cfg_we,
    input  logic                                          cfg_addr,
    input  logic [INDEX_WIDTH-1:0]                        cfg_wdata
);

    logic             push_valid;
    logic             push_ready;
    usg_pkg::bundle_t push_data;
    logic             pop_valid;
    logic             pop_ready;
    usg_pkg::bundle_t pop_data;

    // front: takes tile words, builds sine and cosine of the top, bottom, left and right edge angles
    usg_front #(.INDEX_WIDTH(INDEX_WIDTH)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .band_index  (s_tdata[INDEX_WIDTH-1:0]),
        .wedge_index (s_tdata[2*INDEX_WIDTH-1:INDEX_WIDTH]),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    // two tiles of angle data between front and back
    usg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_data  (pop_data)
    );

    // back: forms the six vertices and drives the output register
    usg_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- src/usg_checker.sv -----
module usg_checker #(
    parameter int FRAC_BITS = 14
)
(
    input logic                                          clk,
    input logic                                          rst_n,
    input logic                                          s_tvalid,
    input logic                                          s_tready,
    input logic                                          m_tvalid,
    input logic                                          m_tready,
    input logic [((6 * FRAC_BITS + 9 + 7) / 8) * 8 - 1:0] m_tdata,
    input logic                                          m_tlast
);

    localparam int F = FRAC_BITS;

    logic [2:0] word_cnt_reg;
    logic [3:0] tiles_reg;
    logic       in_hs;
    logic       out_hs;
    logic       dx_ok;
    logic       dy_ok;
    logic       dz_ok;

    // twice the position and the normal differ by at most one lsb
    function automatic logic close(input logic signed [F:0] p, input logic signed [F+1:0] n);
        logic signed [F+3:0] d;
        d = (F+4)'(p) + (F+4)'(p) - (F+4)'(n);
        close = (d >= -1) && (d <= 1);
    endfunction

    assign in_hs  = s_tvalid && s_tready;
    assign out_hs = m_tvalid && m_tready;
    assign dx_ok  = close(m_tdata[F:0], m_tdata[3*F+3 +: F+2]);
    assign dy_ok  = close(m_tdata[F+1 +: F+1], m_tdata[4*F+5 +: F+2]);
    assign dz_ok  = close(m_tdata[2*F+2 +: F+1], m_tdata[5*F+7 +: F+2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_cnt_reg <= '0;
            tiles_reg    <= '0;
        end
        else
        begin
            if (out_hs)
                word_cnt_reg <= (word_cnt_reg == 3'd5) ? 3'd0 : word_cnt_reg + 3'd1;
            if (in_hs && !(out_hs && m_tlast))
                tiles_reg <= tiles_reg + 4'd1;
            else if (!in_hs && out_hs && m_tlast)
                tiles_reg <= tiles_reg - 4'd1;
        end
    end

    a_last_sixth: assert property (@(posedge clk) disable iff (!rst_n)
        out_hs |-> (m_tlast == (word_cnt_reg == 3'd5)))
        else $error("tlast not on the sixth word of a tile");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (tiles_reg != 4'd0))
        else $error("output word without an open tile");

    a_norm_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (dx_ok && dy_ok && dz_ok))
        else $error("normal does not match twice the position");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled output word changed");

endmodule

bind uv_sphere_tile_generator usg_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_usg_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

// expected vertex words of the sphere tiles and the comparison against them
class tile_scoreboard;
    typedef struct packed {
        logic [14:0] px, py, pz;
        logic [15:0] nx, ny, nz;
        logic        last;
    } vertex_t;

    localparam longint unsigned Q_ONE     = 64'h4000_0000_0000_0000;
    localparam longint unsigned QUARTER_PI = 64'h3243_F6A8_885A_308D;

    vertex_t         vertex_q[$];
    int unsigned     band_reg = 2;
    int unsigned     wedge_reg = 3;
    int              mismatches = 0;

    function void write_reg(logic addr, logic [7:0] value);
        if (addr == usg_pkg::REG_BAND_COUNT)
            band_reg = value;
        else
            wedge_reg = value;
    endfunction

    // Q62 product, truncated
    static function longint unsigned qmul(longint unsigned x, longint unsigned y);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        return p[125:62];
    endfunction

    // sine and cosine of an angle in [0, pi/4] by Horner series
    static function void octant_sincos(longint unsigned a, output longint unsigned s,
                                       output longint unsigned c);
        longint unsigned sdiv[5];
        longint unsigned cdiv[6];
        longint unsigned a2, ts, tc;
        sdiv = '{110, 72, 42, 20, 6};
        cdiv = '{132, 90, 56, 30, 12, 2};
        a2 = qmul(a, a);
        ts = Q_ONE;
        tc = Q_ONE;
        for (int i = 0; i < 5; i++)
            ts = Q_ONE - qmul(a2, ts) / sdiv[i];
        for (int i = 0; i < 6; i++)
            tc = Q_ONE - qmul(a2, tc) / cdiv[i];
        s = qmul(a, ts);
        c = tc;
    endfunction

    // sine and cosine of num/den of a full turn, magnitude plus sign
    static function void turn_sincos(longint unsigned num, longint unsigned den,
                                     output longint unsigned smag, output bit sneg,
                                     output longint unsigned cmag, output bit cneg);
        longint unsigned n8, oct, rem, q, r, s0, c0, s, c;
        n8  = 8 * (num % den);
        oct = n8 / den;
        rem = n8 % den;
        q   = QUARTER_PI / den;
        r   = QUARTER_PI % den;
        // odd octants mirror the angle
        if (oct[0])
            rem = den - rem;
        octant_sincos(rem * q + (rem * r) / den, s0, c0);
        if (oct[0]) begin s = c0; c = s0; end
        else begin s = s0; c = c0; end
        case (oct[2:1])
            2'd0: begin smag = s; sneg = 0; cmag = c; cneg = 0; end
            2'd1: begin smag = c; sneg = 0; cmag = s; cneg = 1; end
            2'd2: begin smag = s; sneg = 1; cmag = c; cneg = 1; end
            default: begin smag = c; sneg = 1; cmag = s; cneg = 0; end
        endcase
    endfunction

    // round to nearest on the magnitude, ties away from zero, then sign
    static function longint unsigned round_q(longint unsigned mag, bit neg, int drop);
        longint unsigned v;
        v = (mag + (64'd1 << (drop - 1))) >> drop;
        return neg ? (64'd0 - v) : v;
    endfunction

    function void note_tile(logic [7:0] band, logic [7:0] wedge);
        longint unsigned bands, wedges;
        longint unsigned sp[2], cp[2], st[2], ct[2];
        bit spn[2], cpn[2], stn[2], ctn[2];
        int boff[6], woff[6];
        longint unsigned xm, zm;
        bit xn, zn;
        vertex_t v;
        boff = '{0, 1, 1, 0, 1, 0};
        woff = '{0, 0, 1, 0, 1, 1};
        // counts below the minimum act as the minimum
        bands  = band_reg < 2 ? 2 : band_reg;
        wedges = wedge_reg < 3 ? 3 : wedge_reg;
        for (int i = 0; i < 2; i++) begin
            turn_sincos(band + i, 2 * bands, sp[i], spn[i], cp[i], cpn[i]);
            turn_sincos(wedge + i, wedges, st[i], stn[i], ct[i], ctn[i]);
        end
        for (int i = 0; i < 6; i++) begin
            xm = qmul(sp[boff[i]], ct[woff[i]]);
            xn = spn[boff[i]] != ctn[woff[i]];
            zm = qmul(sp[boff[i]], st[woff[i]]);
            zn = !(spn[boff[i]] != stn[woff[i]]);
            v.px = 15'(round_q(xm, xn, 49));
            v.py = 15'(round_q(cp[boff[i]], cpn[boff[i]], 49));
            v.pz = 15'(round_q(zm, zn, 49));
            v.nx = 16'(round_q(xm, xn, 48));
            v.ny = 16'(round_q(cp[boff[i]], cpn[boff[i]], 48));
            v.nz = 16'(round_q(zm, zn, 48));
            v.last = (i == 5);
            vertex_q.insert(vertex_q.size(), v);
        end
    endfunction

    function void check_word(logic [95:0] data, logic last);
        vertex_t e, a;
        a.px = data[14:0];
        a.py = data[29:15];
        a.pz = data[44:30];
        a.nx = data[60:45];
        a.ny = data[76:61];
        a.nz = data[92:77];
        a.last = last;
        if (vertex_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected vertex word %h last %b", data, last);
            return;
        end
        e = vertex_q.pop_front();
        if (a != e || data[95:93] != 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("vertex mismatch: exp %h %h %h %h %h %h %b  got %h %h %h %h %h %h %b",
                         e.px, e.py, e.pz, e.nx, e.ny, e.nz, e.last,
                         a.px, a.py, a.pz, a.nx, a.ny, a.nz, a.last);
        end
    endfunction
endclass

module tb_top;
    localparam int LIMIT = 3_000_000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // band_index [7:0], wedge_index [15:8]
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // pos_x, pos_y, pos_z (15 bits each), norm_x, norm_y, norm_z (16 bits each), zero fill
    logic [95:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic        cfg_addr;
    logic [7:0]  cfg_wdata;

    tile_scoreboard tiles = new();
    int unsigned    cycles = 0;
    int unsigned    words_seen = 0;
    bit             steady = 0;   // no random idling on either side while set

    uv_sphere_tile_generator dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off after the first few tiles
    initial
    begin
        m_tready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                tiles.check_word(m_tdata, m_tlast);
                words_seen++;
                if (words_seen == 30)
                begin
                    // let the block back up and stall its input
                    m_tready <= 0;
                    repeat (4000) @(posedge clk);
                end
            end
            m_tready <= steady || ($urandom_range(99) >= 31);
        end
    end

    // one register write, with the write enable taken low again before the task returns
    task automatic cfg_write(logic addr, logic [7:0] value);
        cfg_we    <= 1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 0;
        tiles.write_reg(addr, value);
        @(posedge clk);
    endtask

    // offer one tile, hold it until accepted
    task automatic send_tile(logic [7:0] band, logic [7:0] wedge);
        if (!steady && $urandom_range(99) < 31)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {wedge, band};
        do @(posedge clk); while (!s_tready);
        tiles.note_tile(band, wedge);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (tiles.vertex_q.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // directed corners then random tiles, mostly inside the configured grid
    task automatic run_phase(int n_rand);
        int unsigned nb, nw;
        nb = tiles.band_reg < 2 ? 2 : tiles.band_reg;
        nw = tiles.wedge_reg < 3 ? 3 : tiles.wedge_reg;
        send_tile(0, 0);
        send_tile(8'(nb - 1), 8'(nw - 1));
        send_tile(8'(nb), 8'(nw));
        send_tile(8'hff, 8'hff);
        send_tile(8'hff, 0);
        for (int i = 0; i < n_rand; i++)
        begin
            if ($urandom_range(3) == 0)
                send_tile(8'($urandom_range(255)), 8'($urandom_range(255)));
            else
                send_tile(8'($urandom_range(nb - 1)), 8'($urandom_range(nw - 1)));
        end
        drain();
    endtask

    initial
    begin
        rst_n     = 0;
        s_tvalid  = 0;
        s_tdata   = 0;
        cfg_we    = 0;
        cfg_addr  = usg_pkg::REG_BAND_COUNT;
        cfg_wdata = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset counts: 2 bands, 3 wedges
        run_phase(60);

        // counts below the minimum
        cfg_write(usg_pkg::REG_BAND_COUNT, 0);
        cfg_write(usg_pkg::REG_WEDGE_COUNT, 1);
        run_phase(50);

        // largest counts, no idling
        cfg_write(usg_pkg::REG_BAND_COUNT, 255);
        cfg_write(usg_pkg::REG_WEDGE_COUNT, 255);
        steady = 1;
        run_phase(80);
        steady = 0;

        cfg_write(usg_pkg::REG_BAND_COUNT, 1);
        cfg_write(usg_pkg::REG_WEDGE_COUNT, 2);
        run_phase(40);

        cfg_write(usg_pkg::REG_BAND_COUNT, 16);
        cfg_write(usg_pkg::REG_WEDGE_COUNT, 24);
        run_phase(60);

        cfg_write(usg_pkg::REG_BAND_COUNT, 8'($urandom_range(255)));
        cfg_write(usg_pkg::REG_WEDGE_COUNT, 8'($urandom_range(255)));
        run_phase(60);

        if (tiles.mismatches == 0 && tiles.vertex_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
